[rtl/adcscr_pkg.sv]
package adcscr_pkg;

	// width of the half period and end gap down-counter
	localparam int TIMER_BITS = 24;

	localparam int HALF_W     = 16;
	localparam int GAP_W      = 24;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 24;
	localparam int BITCNT_W   = 5;
	localparam int VALUE_W    = 8;
	localparam int IN_TDATA_W = 8;
	localparam int OUT_TDATA_W = 16;

	localparam logic [BITCNT_W-1:0] CMD_LAST_BIT  = BITCNT_W'(2);
	localparam logic [BITCNT_W-1:0] SAMPLE_FIRST  = BITCNT_W'(1);
	localparam logic [BITCNT_W-1:0] SAMPLE_LAST   = BITCNT_W'(8);
	localparam logic [BITCNT_W-1:0] READ_PULSES   = BITCNT_W'(16);

	localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(1000);
	localparam logic [GAP_W-1:0]  GAP_RESET  = GAP_W'(250000);

	localparam logic [32:0] TIMER_MAX_W = 33'((64'd1 << TIMER_BITS) - 64'd1);

	typedef logic [TIMER_BITS-1:0] timer_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HALF_PERIOD = 1'b0,
		REG_END_GAP     = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_SETUP = 3'd1,
		PH_CDATA = 3'd2,
		PH_CHIGH = 3'd3,
		PH_CLOW  = 3'd4,
		PH_RHIGH = 3'd5,
		PH_RLOW  = 3'd6,
		PH_GAP   = 3'd7
	} phase_t;

	typedef struct packed {
		logic [HALF_W-1:0] half_period_cycles;
		logic [GAP_W-1:0]  end_gap_cycles;
	} cfg_t;

	typedef struct packed {
		logic data_pin;
		logic channel;
		logic start_req;
	} in_item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               done_res;
		logic               busy_res;
		logic               di_drive;
		logic               di_out;
		logic               sclk;
		logic               cs_n;
	} res_t;

	// reload for one serial half period, zero acts as one
	function automatic timer_t half_load(input logic [HALF_W-1:0] hp);
		timer_t r;
		if (hp == '0)
			r = '0;
		else
			r = timer_t'(hp - HALF_W'(1));
		return r;
	endfunction

	// reload for the end gap, saturating at the counter's largest value
	function automatic timer_t gap_load(input logic [GAP_W-1:0] g);
		logic [GAP_W-1:0] gm1;
		timer_t           r;
		gm1 = g - GAP_W'(1);
		if ({9'b0, gm1} > TIMER_MAX_W)
			r = '1;
		else
			r = timer_t'(gm1);
		return r;
	endfunction

endpackage

[rtl/adcscr_cfg.sv]
module adcscr_cfg
	import adcscr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	logic [HALF_W-1:0] half_q;
	logic [GAP_W-1:0]  gap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= HALF_RESET;
			gap_q  <= GAP_RESET;
		end else if (wr_en) begin
			unique case (cfg_reg_t'(wr_index))
				REG_HALF_PERIOD: half_q <= wr_data[HALF_W-1:0];
				REG_END_GAP:     gap_q  <= wr_data[GAP_W-1:0];
				default:         ;
			endcase
		end
	end

	assign cfg.half_period_cycles = half_q;
	assign cfg.end_gap_cycles     = gap_q;

endmodule

[rtl/adcscr_core.sv]
module adcscr_core
	import adcscr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  in_item_t item,
	input  cfg_t     cfg,
	output res_t     res
);

	phase_t               phase_q, phase_d;
	logic [BITCNT_W-1:0]  bitcnt_q, bitcnt_d;
	timer_t               timer_q, timer_d;
	logic [VALUE_W-1:0]   shift_q, shift_d;
	logic                 chan_q, chan_d;
	logic [VALUE_W-1:0]   value_q, value_d;
	logic                 done_d;
	logic                 sampling;
	timer_t               hl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			bitcnt_q <= '0;
			timer_q  <= '0;
			shift_q  <= '0;
			chan_q   <= 1'b0;
			value_q  <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			bitcnt_q <= bitcnt_d;
			timer_q  <= timer_d;
			shift_q  <= shift_d;
			chan_q   <= chan_d;
			value_q  <= value_d;
		end
	end

	assign hl       = half_load(cfg.half_period_cycles);
	assign sampling = (phase_q == PH_RHIGH) && (bitcnt_q >= SAMPLE_FIRST)
		&& (bitcnt_q <= SAMPLE_LAST);

	always_comb begin
		phase_d  = phase_q;
		bitcnt_d = bitcnt_q;
		timer_d  = timer_q;
		shift_d  = shift_q;
		chan_d   = chan_q;
		value_d  = value_q;
		done_d   = 1'b0;
		if (phase_q == PH_IDLE) begin
			if (item.start_req) begin
				chan_d   = item.channel;
				bitcnt_d = '0;
				shift_d  = '0;
				phase_d  = PH_SETUP;
				timer_d  = hl;
			end
		end else if (timer_q != '0) begin
			timer_d = timer_q - timer_t'(1);
		end else begin
			unique case (phase_q)
				PH_SETUP: begin
					phase_d  = PH_CDATA;
					bitcnt_d = '0;
					timer_d  = hl;
				end
				PH_CDATA: begin
					phase_d = PH_CHIGH;
					timer_d = hl;
				end
				PH_CHIGH: begin
					phase_d = PH_CLOW;
					timer_d = hl;
				end
				PH_CLOW: begin
					if (bitcnt_q < CMD_LAST_BIT) begin
						bitcnt_d = bitcnt_q + BITCNT_W'(1);
						phase_d  = PH_CDATA;
					end else begin
						bitcnt_d = '0;
						phase_d  = PH_RHIGH;
					end
					timer_d = hl;
				end
				PH_RHIGH: begin
					if (sampling)
						shift_d = {shift_q[VALUE_W-2:0], item.data_pin};
					phase_d = PH_RLOW;
					timer_d = hl;
				end
				PH_RLOW: begin
					if (bitcnt_q < READ_PULSES) begin
						bitcnt_d = bitcnt_q + BITCNT_W'(1);
						phase_d  = PH_RHIGH;
						timer_d  = hl;
					end else if (cfg.end_gap_cycles == '0) begin
						phase_d  = PH_IDLE;
						bitcnt_d = '0;
						timer_d  = '0;
						value_d  = shift_q;
						done_d   = 1'b1;
					end else begin
						phase_d = PH_GAP;
						timer_d = gap_load(cfg.end_gap_cycles);
					end
				end
				PH_GAP: begin
					phase_d  = PH_IDLE;
					bitcnt_d = '0;
					timer_d  = '0;
					value_d  = shift_q;
					done_d   = 1'b1;
				end
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	// result levels follow the updated state
	always_comb begin
		res.cs_n     = (phase_d == PH_IDLE) || (phase_d == PH_GAP);
		res.sclk     = (phase_d == PH_CHIGH) || (phase_d == PH_RHIGH);
		res.di_out   = 1'b0;
		res.di_drive = 1'b1;
		if (phase_d == PH_CDATA || phase_d == PH_CHIGH || phase_d == PH_CLOW) begin
			res.di_out = (bitcnt_d >= CMD_LAST_BIT) ? chan_d : 1'b1;
		end else if (phase_d == PH_RHIGH || phase_d == PH_RLOW) begin
			if (bitcnt_d == '0)
				res.di_out = chan_d;
			else
				res.di_drive = 1'b0;
		end
		res.busy_res = (phase_d != PH_IDLE);
		res.done_res = done_d;
		res.value    = value_d;
	end

	a_bitcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		bitcnt_q <= READ_PULSES)
		else $error("bit counter beyond read pulse count");

	a_cmd_bits: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_CDATA || phase_q == PH_CHIGH || phase_q == PH_CLOW)
		|-> bitcnt_q <= CMD_LAST_BIT)
		else $error("command bit index out of range");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && done_d) |=> (phase_q == PH_IDLE && bitcnt_q == '0))
		else $error("done without return to idle");

	a_hold_no_step: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> ($stable(phase_q) && $stable(timer_q) && $stable(value_q)))
		else $error("state moved without a step");

endmodule

[rtl/adc_serial_channel_read_top.sv]
// serial master for a two-channel 8-bit converter (chip select, serial clock,
// one shared data line); one input transfer is one tick of the serial engine
// input stream s_*: each transfer carries start_req, channel and the sampled
// level of the converter's data output; each one yields exactly one result
// output stream m_*: the pin levels and status after that tick plus the last
// converted byte; done_res is high in the one result where the byte is new
// config channel cfg_*: index 0 half period in cycles (16 bit, 0 acts as 1),
// index 1 end gap in cycles (24 bit); cfg_ready is always high, write only
// while the stream is drained
// path: an input transfer lands in the input register; once the result
// register is free or draining, the serial engine runs on it and loads the
// result register, which raises m_tvalid
// throughput: one transfer per cycle while the receiver does not stall; the
// engine update is combinational between the two registers
// receiver stall: the result register holds; the input register still takes
// one more transfer, then s_tready drops until m_tready returns
// reset: engine idle, value zero, no result valid, half period 1000 and
// end gap 250000
module adc_serial_channel_read_top
	import adcscr_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // start_req, channel, data_pin, zero pad
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // cs_n, sclk, di_out, di_drive,
	                                          // busy_res, done_res, value[7:0], zero pad
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	in_item_t in_s1;
	logic     valid_s1;
	res_t     res_q;
	logic     out_valid_q;
	res_t     res_d;
	cfg_t     cfg;
	logic     step;

	// engine runs when an item waits and the result slot is free or draining
	assign step     = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || step;
	assign cfg_ready = 1'b1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_s1.start_req <= s_tdata[0];
			in_s1.channel   <= s_tdata[1];
			in_s1.data_pin  <= s_tdata[2];
		end
	end

	adcscr_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	adcscr_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (in_s1),
		.cfg    (cfg),
		.res    (res_d)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W - 6 - VALUE_W){1'b0}}, res_q.value, res_q.done_res,
		res_q.busy_res, res_q.di_drive, res_q.di_out, res_q.sclk, res_q.cs_n};

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import adcscr_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SHOW_LIMIT  = 50;

	// host side work list: one serial engine tick or one register write
	typedef enum logic {
		OP_TICK,
		OP_REG_WRITE
	} host_op_kind_t;

	typedef struct {
		host_op_kind_t           kind;
		in_item_t                item;
		cfg_reg_t                idx;
		logic [CFG_DATA_W-1:0]   data;
	} host_op_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	cfg_reg_t               cfg_index = REG_HALF_PERIOD;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	host_op_t host_ops[$];
	res_t     tick_results_q[$];

	// mirror of the serial engine
	logic [HALF_W-1:0]   half_cfg;
	logic [GAP_W-1:0]    gap_cfg;
	phase_t              eng_phase;
	logic [BITCNT_W-1:0] bit_cnt;
	timer_t              tmr;
	logic [VALUE_W-1:0]  shreg;
	logic                chan_l;
	logic [VALUE_W-1:0]  byte_out;

	int mismatches = 0;
	int results_seen = 0;
	int cycles = 0;

	adc_serial_channel_read_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// serial half period reload; a zero setting behaves as a setting of one
	function automatic timer_t half_reload();
		if (half_cfg == '0)
			return '0;
		return timer_t'(half_cfg - HALF_W'(1));
	endfunction

	// one tick of the engine, returns pin levels and status after it
	function automatic res_t adc_tick(input in_item_t it);
		res_t            r;
		logic            finished;
		longint unsigned gm1;
		finished = 1'b0;
		if (eng_phase == PH_IDLE) begin
			// a request is only taken while idle
			if (it.start_req) begin
				chan_l = it.channel;
				bit_cnt = '0;
				shreg = '0;
				eng_phase = PH_SETUP;
				tmr = half_reload();
			end
		end else if (tmr != '0) begin
			tmr = tmr - timer_t'(1);
		end else begin
			// msb-first reply bits are taken at the end of their clock-high half
			if (eng_phase == PH_RHIGH && bit_cnt >= SAMPLE_FIRST && bit_cnt <= SAMPLE_LAST)
				shreg = {shreg[VALUE_W-2:0], it.data_pin};
			case (eng_phase)
				PH_SETUP: begin
					eng_phase = PH_CDATA;
					bit_cnt = '0;
					tmr = half_reload();
				end
				PH_CDATA: begin
					eng_phase = PH_CHIGH;
					tmr = half_reload();
				end
				PH_CHIGH: begin
					eng_phase = PH_CLOW;
					tmr = half_reload();
				end
				PH_CLOW: begin
					if (bit_cnt < CMD_LAST_BIT) begin
						bit_cnt = bit_cnt + BITCNT_W'(1);
						eng_phase = PH_CDATA;
					end else begin
						bit_cnt = '0;
						eng_phase = PH_RHIGH;
					end
					tmr = half_reload();
				end
				PH_RHIGH: begin
					eng_phase = PH_RLOW;
					tmr = half_reload();
				end
				PH_RLOW: begin
					if (bit_cnt < READ_PULSES) begin
						bit_cnt = bit_cnt + BITCNT_W'(1);
						eng_phase = PH_RHIGH;
						tmr = half_reload();
					end else if (gap_cfg == '0) begin
						finished = 1'b1;
					end else begin
						// end gap, clipped to the widest count the timer holds
						gm1 = longint'(gap_cfg) - 1;
						if (gm1 > ((64'd1 << TIMER_BITS) - 64'd1))
							tmr = '1;
						else
							tmr = timer_t'(gm1);
						eng_phase = PH_GAP;
					end
				end
				PH_GAP: finished = 1'b1;
				default: eng_phase = PH_IDLE;
			endcase
			if (finished) begin
				eng_phase = PH_IDLE;
				bit_cnt = '0;
				tmr = '0;
				byte_out = shreg;
			end
		end

		r.cs_n = (eng_phase == PH_IDLE || eng_phase == PH_GAP);
		r.sclk = (eng_phase == PH_CHIGH || eng_phase == PH_RHIGH);
		r.di_out = 1'b0;
		r.di_drive = 1'b1;
		if (eng_phase == PH_CDATA || eng_phase == PH_CHIGH || eng_phase == PH_CLOW) begin
			// start and mode bits are ones, the third command bit is the channel
			r.di_out = (bit_cnt >= CMD_LAST_BIT) ? chan_l : 1'b1;
		end else if (eng_phase == PH_RHIGH || eng_phase == PH_RLOW) begin
			// the extra pulse keeps the channel bit on the line, then release it
			if (bit_cnt == '0)
				r.di_out = chan_l;
			else
				r.di_drive = 1'b0;
		end
		r.busy_res = (eng_phase != PH_IDLE);
		r.done_res = finished;
		r.value = byte_out;
		return r;
	endfunction

	task automatic push_tick(input logic start, input logic ch, input logic pin);
		host_op_t op;
		op.kind = OP_TICK;
		op.item.start_req = start;
		op.item.channel = ch;
		op.item.data_pin = pin;
		op.idx = REG_HALF_PERIOD;
		op.data = '0;
		host_ops.push_back(op);
	endtask

	task automatic push_reg(input cfg_reg_t idx, input int unsigned val);
		host_op_t op;
		op.kind = OP_REG_WRITE;
		op.item = '0;
		op.idx = idx;
		op.data = val[CFG_DATA_W-1:0];
		host_ops.push_back(op);
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= SHOW_LIMIT)
				$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	// driver: ticks go out in bursts with random gaps; register writes wait
	// until every pending result is back, which also pauses the sender
	int burst_left = 8;
	int gap_left = 0;

	always @(posedge clk) begin
		host_op_t op;
		logic     nxt_valid;
		logic     nxt_cfg;
		logic     took_tick;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			took_tick = s_tvalid && s_tready;
			// predict on the accepting edge
			if (took_tick)
				tick_results_q.push_back(adc_tick(in_item_t'(s_tdata[$bits(in_item_t)-1:0])));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_HALF_PERIOD: half_cfg = cfg_data[HALF_W-1:0];
					REG_END_GAP:     gap_cfg = cfg_data[GAP_W-1:0];
					default: ;
				endcase
			end

			// an offer that was not taken stays up unchanged
			nxt_valid = s_tvalid && !s_tready;
			nxt_cfg = cfg_valid && !cfg_ready;
			if (!nxt_valid && !nxt_cfg && host_ops.size() > 0) begin
				if (host_ops[0].kind == OP_TICK) begin
					if (gap_left > 0) begin
						gap_left--;
					end else begin
						op = host_ops.pop_front();
						s_tdata <= IN_TDATA_W'(op.item);
						nxt_valid = 1'b1;
						burst_left--;
						if (burst_left <= 0) begin
							burst_left = $urandom_range(1, 40);
							gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
						end
					end
				end else if (tick_results_q.size() == 0 && !took_tick) begin
					// stream fully drained, safe to touch a register
					op = host_ops.pop_front();
					cfg_index <= op.idx;
					cfg_data <= op.data;
					nxt_cfg = 1'b1;
				end
			end
			s_tvalid <= nxt_valid;
			cfg_valid <= nxt_cfg;
		end
	end

	// monitor: checks every result transfer and stalls on its own pattern,
	// with one long hold-off so the input side backs up
	int stall_mode = 0;
	int mode_left = 0;
	int hold_left = 0;
	logic held_once = 1'b0;

	always @(posedge clk) begin
		res_t got;
		res_t want;
		logic rdy;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = res_t'(m_tdata[$bits(res_t)-1:0]);
				results_seen++;
				if (tick_results_q.size() == 0) begin
					mismatches++;
					if (mismatches <= SHOW_LIMIT)
						$display("%0t: result transfer with nothing expected, actual %h",
							$time, m_tdata);
				end else begin
					want = tick_results_q.pop_front();
					check_field("cs_n", 32'(want.cs_n), 32'(got.cs_n));
					check_field("sclk", 32'(want.sclk), 32'(got.sclk));
					check_field("di_out", 32'(want.di_out), 32'(got.di_out));
					check_field("di_drive", 32'(want.di_drive), 32'(got.di_drive));
					check_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
					check_field("done_res", 32'(want.done_res), 32'(got.done_res));
					check_field("value", 32'(want.value), 32'(got.value));
				end
			end

			if (!held_once && results_seen >= 400) begin
				held_once = 1'b1;
				hold_left = 300;
			end
			if (mode_left <= 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 120);
			end
			mode_left--;
			case (stall_mode)
				0: rdy = 1'b1;
				1: rdy = 1'($urandom_range(0, 1));
				2: rdy = ($urandom_range(0, 3) == 0);
				default: rdy = ($urandom_range(0, 7) != 0);
			endcase
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end
			m_tready <= rdy;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL adc_serial_channel_read_top");
			$finish;
		end
	end

	initial begin
		int unsigned half_set[8];
		int unsigned gap_set[8];
		half_cfg = HALF_RESET;
		gap_cfg = GAP_RESET;
		eng_phase = PH_IDLE;
		bit_cnt = '0;
		tmr = '0;
		shreg = '0;
		chan_l = 1'b0;
		byte_out = '0;

		// reset settings: idle ticks only, a conversion here would take far too long
		push_tick(1'b0, 1'b1, 1'b1);
		push_tick(1'b0, 1'b0, 1'b0);
		push_tick(1'b0, 1'b1, 1'b0);
		push_tick(1'b0, 1'b0, 1'b1);

		// directed: zero half period, no end gap, channel one then a request while busy
		push_reg(REG_HALF_PERIOD, 0);
		push_reg(REG_END_GAP, 0);
		push_tick(1'b1, 1'b1, 1'b1);
		push_tick(1'b1, 1'b0, 1'b0);
		for (int i = 0; i < 20; i++)
			push_tick(1'b1, i[0], (i % 3) != 0);

		// random phases, mostly the shortest half period settings so conversions finish often
		half_set = '{0, 1, 2, 1, 3, 0, 1, 2};
		gap_set = '{0, 1, 2, $urandom_range(3, 30), 0, 1, $urandom_range(0, 7), 5};
		for (int p = 0; p < 8; p++) begin
			if (p > 0) begin
				push_reg(REG_HALF_PERIOD, half_set[p]);
				push_reg(REG_END_GAP, gap_set[p]);
			end
			for (int i = 0; i < 150; i++)
				push_tick($urandom_range(0, 7) != 0, 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
		end

		// widest end gap: the engine parks in the gap with the timer loaded from the widest setting
		push_reg(REG_HALF_PERIOD, 1);
		push_reg(REG_END_GAP, 24'hFF_FFFF);
		for (int i = 0; i < 60; i++)
			push_tick(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		push_reg(REG_HALF_PERIOD, 16'hFFFF);
		for (int i = 0; i < 6; i++)
			push_tick(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (host_ops.size() > 0 || s_tvalid || cfg_valid || tick_results_q.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatches == 0)
			$display("PASS adc_serial_channel_read_top");
		else
			$display("FAIL adc_serial_channel_read_top");
		$finish;
	end

endmodule
